[rtl/core/pfl_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfl_pkg
// Shared constants, register indexes and types of the protection fault latch.
// ----------------------------------------------------------------------------
package pfl_pkg;

  localparam int WORD_BITS = 16;
  localparam int NUM_MODES = 4;

  localparam int LANE_BITS = 16;
  localparam int CFG_BITS  = 64;
  localparam int MODE_BITS = 3;
  localparam int LAST_BITS = 2;

  localparam logic [MODE_BITS-1:0] MODE_LIMIT = MODE_BITS'(NUM_MODES);
  localparam logic [LAST_BITS-1:0] LAST_RESET = LAST_BITS'(3);

  typedef logic [WORD_BITS-1:0] word_t;

  typedef enum logic [2:0] {
    REG_ACTIVE      = 3'd0,
    REG_NORMAL      = 3'd1,
    REG_ALARM       = 3'd2,
    REG_NORMAL_REL  = 3'd3,
    REG_ALARM_REL   = 3'd4,
    REG_BAN         = 3'd5,
    REG_LAST_STATE  = 3'd6
  } cfg_index_t;

  typedef struct packed {
    word_t act;
    word_t nm;
    word_t am;
    word_t nrel;
    word_t arel;
    word_t ban;
  } pfl_lanes_t;

  function automatic word_t lane_sel(input logic [CFG_BITS-1:0] packed_masks,
                                     input logic [LAST_BITS-1:0] sel);
    logic [LANE_BITS-1:0] l;
    l = packed_masks[{sel, 4'b0000} +: LANE_BITS];
    return l[WORD_BITS-1:0];
  endfunction

endpackage
`default_nettype wire

[rtl/core/protection_fault_latch.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// protection_fault_latch
// Per-mode protection fault latch with stop requests, hold and start ban.
//
//   channel  direction  handshake          payload
//   in       input      in_valid/in_stall  fault_word, mode_index, clear_request
//   out      output     out_valid/out_stall active/latched/normal/alarm words,
//                                          normal_stop, emergency_stop, start_ban,
//                                          accepted
//   cfg      input      cfg_we             cfg_index, cfg_data
//
// one item per cycle while the result is not stalled; input register, then the
// update logic into the state/result register
// reset clears all latches, flags and masks; last_state resets to 3
// a stalled result holds the state; the input register still takes one item
// ----------------------------------------------------------------------------
module protection_fault_latch
  import pfl_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [2:0]           cfg_index,
  input  wire logic [CFG_BITS-1:0]  cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [15:0]          fault_word,
  input  wire logic [2:0]           mode_index,
  input  wire logic                 clear_request,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [15:0]               active_word,
  output logic [15:0]               latched_word,
  output logic [15:0]               normal_word,
  output logic [15:0]               alarm_word,
  output logic                      normal_stop,
  output logic                      emergency_stop,
  output logic                      start_ban,
  output logic                      accepted
);

  logic                 s1_valid;
  word_t                s1_word;
  logic [MODE_BITS-1:0] s1_mode;
  logic                 s1_clr;
  logic                 advance, fire, load;

  pfl_lanes_t           lanes;
  logic [LAST_BITS-1:0] last_state;
  word_t                active_reg, latched_reg, normal_reg, alarm_reg;

  assign advance  = !out_valid || !out_stall;
  assign fire     = s1_valid && advance;
  assign in_stall = s1_valid && !advance;
  assign load     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (advance || !s1_valid) begin
        s1_valid <= in_valid;
      end
      if (advance) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_word <= fault_word[WORD_BITS-1:0];
      s1_mode <= mode_index;
      s1_clr  <= clear_request;
    end
  end

  pfl_cfg u_cfg (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .lane_index (s1_mode[LAST_BITS-1:0]),
    .lanes      (lanes),
    .last_state (last_state)
  );

  pfl_step u_step (
    .clk                (clk),
    .rst                (rst),
    .fire               (fire),
    .word               (s1_word),
    .mode               (s1_mode),
    .clr                (s1_clr),
    .lanes              (lanes),
    .last_state         (last_state),
    .active_reg         (active_reg),
    .latched_reg        (latched_reg),
    .normal_reg         (normal_reg),
    .alarm_reg          (alarm_reg),
    .normal_stop_reg    (normal_stop),
    .emergency_stop_reg (emergency_stop),
    .start_ban_reg      (start_ban),
    .accepted_reg       (accepted)
  );

  assign active_word  = 16'(active_reg);
  assign latched_word = 16'(latched_reg);
  assign normal_word  = 16'(normal_reg);
  assign alarm_word   = 16'(alarm_reg);

  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && out_valid)
    else $error("input stalled with nothing in flight");

  a_fire_gives_result: assert property (@(posedge clk) disable iff (rst)
    fire |=> out_valid)
    else $error("item advanced without a result");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(latched_word) && $stable(accepted))
    else $error("stalled result changed");

endmodule
`default_nettype wire

[rtl/core/pfl_cfg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfl_cfg
// Mask register file with per-mode lane selection.
// ----------------------------------------------------------------------------
module pfl_cfg
  import pfl_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [2:0]            cfg_index,
  input  wire logic [CFG_BITS-1:0]   cfg_data,
  input  wire logic [LAST_BITS-1:0]  lane_index,
  output pfl_lanes_t                 lanes,
  output logic [LAST_BITS-1:0]       last_state
);

  logic [CFG_BITS-1:0] active_masks;
  logic [CFG_BITS-1:0] normal_masks;
  logic [CFG_BITS-1:0] alarm_masks;
  logic [CFG_BITS-1:0] normal_release_masks;
  logic [CFG_BITS-1:0] alarm_release_masks;
  logic [CFG_BITS-1:0] ban_masks;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_masks         <= '0;
      normal_masks         <= '0;
      alarm_masks          <= '0;
      normal_release_masks <= '0;
      alarm_release_masks  <= '0;
      ban_masks            <= '0;
      last_state           <= LAST_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ACTIVE:     active_masks         <= cfg_data;
        REG_NORMAL:     normal_masks         <= cfg_data;
        REG_ALARM:      alarm_masks          <= cfg_data;
        REG_NORMAL_REL: normal_release_masks <= cfg_data;
        REG_ALARM_REL:  alarm_release_masks  <= cfg_data;
        REG_BAN:        ban_masks            <= cfg_data;
        REG_LAST_STATE: last_state           <= cfg_data[LAST_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    lanes.act  = lane_sel(active_masks, lane_index);
    lanes.nm   = lane_sel(normal_masks, lane_index);
    lanes.am   = lane_sel(alarm_masks, lane_index);
    lanes.nrel = lane_sel(normal_release_masks, lane_index);
    lanes.arel = lane_sel(alarm_release_masks, lane_index);
    lanes.ban  = lane_sel(ban_masks, lane_index);
  end

endmodule
`default_nettype wire

[rtl/core/pfl_step.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfl_step
// Latch and pending-word update; the state registers form the result register.
// ----------------------------------------------------------------------------
module pfl_step
  import pfl_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  fire,
  input  wire word_t                 word,
  input  wire logic [MODE_BITS-1:0]  mode,
  input  wire logic                  clr,
  input  wire pfl_lanes_t            lanes,
  input  wire logic [LAST_BITS-1:0]  last_state,
  output word_t                      active_reg,
  output word_t                      latched_reg,
  output word_t                      normal_reg,
  output word_t                      alarm_reg,
  output logic                       normal_stop_reg,
  output logic                       emergency_stop_reg,
  output logic                       start_ban_reg,
  output logic                       accepted_reg
);

  word_t normal_pending, alarm_pending, normal_suppress;
  logic  hold_flag;

  word_t active_next, latched_next, normal_next, alarm_next;
  word_t np_next, ap_next, sup_next, np_mid, ap_mid;
  logic  ok, nstop_next, astop_next, ban_next;

  always_comb begin
    ok = (mode < MODE_LIMIT) &&
         ((mode == '0) || (mode <= {1'b0, last_state}));

    active_next  = word & lanes.act;
    latched_next = latched_reg | active_next;
    normal_next  = normal_reg | (active_next & lanes.nm);
    alarm_next   = alarm_reg | (active_next & lanes.am);

    if (hold_flag) begin
      np_mid = normal_pending;
      ap_mid = alarm_pending;
    end else begin
      np_mid = (normal_pending | (latched_next & lanes.nm)) & ~normal_suppress;
      ap_mid = alarm_pending | (latched_next & lanes.am);
    end

    ap_next  = (ap_mid != '0) ? (ap_mid & ~lanes.arel) : ap_mid;
    np_next  = (np_mid != '0) ? (np_mid & ~lanes.nrel) : np_mid;
    sup_next = (np_mid != '0) ? (normal_suppress | lanes.nrel) : normal_suppress;

    nstop_next = (np_next != '0);
    astop_next = (ap_next != '0);
    ban_next   = (((normal_next | alarm_next) & lanes.ban) != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_reg         <= '0;
      latched_reg        <= '0;
      normal_reg         <= '0;
      alarm_reg          <= '0;
      normal_pending     <= '0;
      alarm_pending      <= '0;
      normal_suppress    <= '0;
      hold_flag          <= 1'b0;
      normal_stop_reg    <= 1'b0;
      emergency_stop_reg <= 1'b0;
      start_ban_reg      <= 1'b0;
      accepted_reg       <= 1'b0;
    end else if (fire) begin
      accepted_reg <= ok;
      if (ok) begin
        normal_pending <= np_next;
        alarm_pending  <= ap_next;
        if (clr) begin
          active_reg         <= '0;
          latched_reg        <= '0;
          normal_reg         <= '0;
          alarm_reg          <= '0;
          normal_suppress    <= '0;
          hold_flag          <= 1'b0;
          normal_stop_reg    <= 1'b0;
          emergency_stop_reg <= 1'b0;
          start_ban_reg      <= 1'b0;
        end else begin
          active_reg         <= active_next;
          latched_reg        <= latched_next;
          normal_reg         <= normal_next;
          alarm_reg          <= alarm_next;
          normal_suppress    <= sup_next;
          hold_flag          <= nstop_next && astop_next;
          normal_stop_reg    <= nstop_next;
          emergency_stop_reg <= astop_next;
          start_ban_reg      <= ban_next;
        end
      end
    end
  end

  // rejected mode leaves every latch untouched
  a_reject_stable: assert property (@(posedge clk) disable iff (rst)
    fire && !ok |=> $stable(latched_reg) && $stable(normal_pending) && !accepted_reg)
    else $error("rejected item changed state");

  // clear wipes latches and flags but still updates the pending words
  a_clear_wipes: assert property (@(posedge clk) disable iff (rst)
    fire && ok && clr |=> latched_reg == '0 && !hold_flag && !normal_stop_reg
                          && normal_pending == $past(np_next))
    else $error("clear did not wipe latches");

  // hold only while both stop requests are raised
  a_hold_stops: assert property (@(posedge clk) disable iff (rst)
    hold_flag |-> normal_stop_reg && emergency_stop_reg)
    else $error("hold without both stops");

  // latched word always covers the active word
  a_latch_cover: assert property (@(posedge clk) disable iff (rst)
    (active_reg & ~latched_reg) == '0)
    else $error("active bit not latched");

endmodule
`default_nettype wire
